FILE: src/assert_macros.svh
// Assertion macros used by the RTL module of the direction quantizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define MDQ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define MDQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mdq_pkg.sv
// Package with the constants and types of the motion direction quantizer.
package mdq_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIR_BITS       = 5;

  localparam logic [DIR_BITS-1:0] DIR_NONE    = 5'd0;
  localparam logic [DIR_BITS-1:0] DIR_EAST    = 5'd1;
  localparam logic [DIR_BITS-1:0] DIR_NORTH   = 5'd5;
  localparam logic [DIR_BITS-1:0] DIR_Q2_BASE = 5'd8;
  localparam logic [DIR_BITS-1:0] DIR_WEST    = 5'd9;
  localparam logic [DIR_BITS-1:0] DIR_SOUTH   = 5'd13;
  localparam logic [DIR_BITS-1:0] DIR_Q4_BASE = 5'd16;

  localparam logic [1:0] RANK_BELOW_22 = 2'd0;
  localparam logic [1:0] RANK_BELOW_45 = 2'd1;
  localparam logic [1:0] RANK_BELOW_67 = 2'd2;
  localparam logic [1:0] RANK_ABOVE_67 = 2'd3;

  typedef struct packed {
    logic have;
    logic x_neg;
    logic y_neg;
    logic x_zero;
    logic y_zero;
  } mdq_flags_t;

endpackage

FILE: src/motion_direction_quantizer_16_top.sv
// Motion direction quantizer: sorts box-center motion into 16 sectors of 22.5 degrees.
//
// Each transaction brings the two corners of a tracked box. The block forms the corner
// sums (twice the box center), subtracts those of the previous transaction and reports
// the motion direction as code 1..16, code 1 starting at 0 degrees and counting
// counterclockwise with y pointing up; code 0 means no earlier box or no motion. The
// sector borders at 22.5 and 67.5 degrees are tested exactly by comparing squares. The
// block is a four-stage pipeline (difference, magnitude, squaring, encoding) that takes
// one transaction per cycle; each stage holds its item only while the stage after it is
// full, so stalls on the output side fill the pipeline before the input side sees
// backpressure.
`include "assert_macros.svh"

module motion_direction_quantizer_16_top
  import mdq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_corner_a_x,
  input  logic [COORD_BITS-1:0] in_corner_a_y,
  input  logic [COORD_BITS-1:0] in_corner_b_x,
  input  logic [COORD_BITS-1:0] in_corner_b_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIR_BITS-1:0]   out_direction
);

  localparam int SumW  = COORD_BITS + 1;
  localparam int DiffW = SumW + 1;
  localparam int Ax2W  = 2 * SumW;
  localparam int SqSW  = 2 * (SumW + 1);

  logic                    prev_have_r;
  logic [SumW-1:0]         prev_sx_r;
  logic [SumW-1:0]         prev_sy_r;

  logic                    s1_v_r;
  logic                    s1_have_r;
  logic signed [DiffW-1:0] s1_dx_r;
  logic signed [DiffW-1:0] s1_dy_r;

  logic                    s2_v_r;
  mdq_flags_t              s2_flags_r;
  logic [SumW-1:0]         s2_ax_r;
  logic [SumW-1:0]         s2_ay_r;

  logic                    s3_v_r;
  mdq_flags_t              s3_flags_r;
  logic [SqSW-1:0]         s3_sqs_r;
  logic [Ax2W-1:0]         s3_ax2_r;
  logic [Ax2W-1:0]         s3_sqd_r;
  logic                    s3_le_r;
  logic                    s3_lt_r;

  logic                    s4_v_r;
  logic [DIR_BITS-1:0]     s4_dir_r;

  logic                    rdy1;
  logic                    rdy2;
  logic                    rdy3;
  logic                    rdy4;
  logic                    in_acc;

  logic [SumW-1:0]         sx_nxt;
  logic [SumW-1:0]         sy_nxt;
  logic signed [DiffW-1:0] dx_nxt;
  logic signed [DiffW-1:0] dy_nxt;

  logic signed [DiffW-1:0] dx_abs;
  logic signed [DiffW-1:0] dy_abs;
  mdq_flags_t              flags_nxt;

  logic [SumW:0]           s_sum;
  logic [SumW-1:0]         d_diff;
  logic [SqSW-1:0]         sqs_nxt;
  logic [Ax2W-1:0]         ax2_nxt;
  logic [Ax2W-1:0]         sqd_nxt;

  logic [SqSW-1:0]         two_ax2;
  logic                    lt22;
  logic                    lt67;
  logic [1:0]              rank_hi;
  logic [1:0]              rank_lo;
  logic [DIR_BITS-1:0]     dir_nxt;

  assign rdy4     = !s4_v_r || out_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;
  assign in_acc   = in_valid && rdy1;

  assign out_valid     = s4_v_r;
  assign out_direction = s4_dir_r;

  // Stage 1: corner sums and signed motion, y flipped to point up.
  always_comb begin
    sx_nxt = SumW'({1'b0, in_corner_a_x}) + SumW'({1'b0, in_corner_b_x});
    sy_nxt = SumW'({1'b0, in_corner_a_y}) + SumW'({1'b0, in_corner_b_y});
    dx_nxt = signed'({1'b0, sx_nxt}) - signed'({1'b0, prev_sx_r});
    dy_nxt = signed'({1'b0, prev_sy_r}) - signed'({1'b0, sy_nxt});
  end

  // Stage 2: magnitudes and quadrant flags.
  always_comb begin
    dx_abs           = s1_dx_r[DiffW-1] ? -s1_dx_r : s1_dx_r;
    dy_abs           = s1_dy_r[DiffW-1] ? -s1_dy_r : s1_dy_r;
    flags_nxt.have   = s1_have_r;
    flags_nxt.x_neg  = s1_dx_r[DiffW-1];
    flags_nxt.y_neg  = s1_dy_r[DiffW-1];
    flags_nxt.x_zero = (s1_dx_r == '0);
    flags_nxt.y_zero = (s1_dy_r == '0);
  end

  // Stage 3: the squares used for the exact tangent tests.
  always_comb begin
    s_sum   = {1'b0, s2_ax_r} + {1'b0, s2_ay_r};
    d_diff  = (s2_ay_r > s2_ax_r) ? (s2_ay_r - s2_ax_r) : '0;
    sqs_nxt = s_sum * s_sum;
    ax2_nxt = s2_ax_r * s2_ax_r;
    sqd_nxt = d_diff * d_diff;
  end

  // Stage 4: sector ranks within the quadrant and final code.
  always_comb begin
    two_ax2 = {1'b0, s3_ax2_r, 1'b0};
    lt22    = (s3_sqs_r < two_ax2);
    lt67    = s3_le_r || ({2'b00, s3_sqd_r} < two_ax2);
    if (lt22) begin
      rank_hi = RANK_BELOW_22;
      rank_lo = RANK_BELOW_22;
    end else begin
      rank_hi = s3_lt_r ? RANK_BELOW_45 : (lt67 ? RANK_BELOW_67 : RANK_ABOVE_67);
      rank_lo = s3_le_r ? RANK_BELOW_45 : (lt67 ? RANK_BELOW_67 : RANK_ABOVE_67);
    end
    if (!s3_flags_r.have || (s3_flags_r.x_zero && s3_flags_r.y_zero)) begin
      dir_nxt = DIR_NONE;
    end else if (s3_flags_r.x_zero) begin
      dir_nxt = s3_flags_r.y_neg ? DIR_SOUTH : DIR_NORTH;
    end else if (s3_flags_r.y_zero) begin
      dir_nxt = s3_flags_r.x_neg ? DIR_WEST : DIR_EAST;
    end else if (!s3_flags_r.x_neg && !s3_flags_r.y_neg) begin
      dir_nxt = DIR_EAST + DIR_BITS'(rank_hi);
    end else if (s3_flags_r.x_neg && s3_flags_r.y_neg) begin
      dir_nxt = DIR_WEST + DIR_BITS'(rank_hi);
    end else if (s3_flags_r.x_neg) begin
      dir_nxt = DIR_Q2_BASE - DIR_BITS'(rank_lo);
    end else begin
      dir_nxt = DIR_Q4_BASE - DIR_BITS'(rank_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_have_r <= 1'b0;
      prev_sx_r   <= '0;
      prev_sy_r   <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_have_r <= 1'b1;
        prev_sx_r   <= sx_nxt;
        prev_sy_r   <= sy_nxt;
      end
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_have_r <= prev_have_r;
      s1_dx_r   <= dx_nxt;
      s1_dy_r   <= dy_nxt;
    end
    if (rdy2) begin
      s2_flags_r <= flags_nxt;
      s2_ax_r    <= dx_abs[SumW-1:0];
      s2_ay_r    <= dy_abs[SumW-1:0];
    end
    if (rdy3) begin
      s3_flags_r <= s2_flags_r;
      s3_sqs_r   <= sqs_nxt;
      s3_ax2_r   <= ax2_nxt;
      s3_sqd_r   <= sqd_nxt;
      s3_le_r    <= (s2_ay_r <= s2_ax_r);
      s3_lt_r    <= (s2_ay_r < s2_ax_r);
    end
    if (rdy4) begin
      s4_dir_r <= dir_nxt;
    end
  end

  `MDQ_ASSERT_NEXT(a_have_set, clk, rst_n, in_acc, prev_have_r, "previous box not recorded")
  `MDQ_ASSERT_NEXT(a_first_item, clk, rst_n, in_acc && !prev_have_r, s1_v_r && !s1_have_r, "first transaction lost its no-previous mark")
  `MDQ_ASSERT_NEXT(a_s3_hold, clk, rst_n, s3_v_r && !rdy4, s3_v_r && $stable(s3_ax2_r) && $stable(s3_flags_r), "stalled stage 3 changed")
  `MDQ_ASSERT_NOW(a_dir_range, clk, rst_n, s4_v_r, s4_dir_r <= DIR_Q4_BASE, "direction code out of range")

endmodule
